// ===== hdl/clnw_pkg.sv =====
// shared types, codes and tables for the character lcd expander byte writer
package clnw_pkg;

  // expander address bases
  localparam logic [7:0] ADDR_BASE_A = 8'h70;
  localparam logic [7:0] ADDR_BASE_B = 8'h40;

  // lcd line start, clear and home commands
  localparam logic [7:0] LINE1_CMD = 8'h80;
  localparam logic [7:0] LINE2_CMD = 8'hC0;
  localparam logic [7:0] LINE3_CMD = 8'h94;
  localparam logic [7:0] LINE4_CMD = 8'hD4;
  localparam logic [7:0] CLEAR_CMD = 8'h01;
  localparam logic [7:0] HOME_CMD_A = 8'h02;
  localparam logic [7:0] HOME_CMD_B = 8'h03;

  // control characters in the text stream
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN = 8'h0D;
  localparam logic [7:0] CH_BELL = 8'h07;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;

  // cursor move limits
  localparam logic [5:0] COL_MAX = 6'd40;

  // sequencer step counter
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd14;

  // default depth of the job queue
  localparam int QUEUE_DEPTH_DEF = 4;

  // input actions
  typedef enum logic [2:0] {
    ACT_TEXT    = 3'd0,
    ACT_COMMAND = 3'd1,
    ACT_CURSOR  = 3'd2,
    ACT_INIT    = 3'd3,
    ACT_LIGHT   = 3'd4
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BACKLIGHT = 2'd0,
    REG_FOUR_LINE = 2'd1,
    REG_VARIANT   = 2'd2,
    REG_ADDR_PINS = 2'd3
  } cfg_reg_t;

  // kinds of queued jobs
  typedef enum logic [1:0] {
    JOB_BYTE  = 2'd0,
    JOB_INIT  = 2'd1,
    JOB_LIGHT = 2'd2
  } job_kind_t;

  // one classified item waiting for the back end
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] value;
    logic       rs;
    logic       lw;
  } job_t;

  // queue status toward front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // start command of a line, zero-based index
  function automatic logic [7:0] line_start(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = LINE1_CMD;
      2'd1: r = LINE2_CMD;
      2'd2: r = LINE3_CMD;
      default: r = LINE4_CMD;
    endcase
    return r;
  endfunction

  // fixed 4-bit init sequence, backlight always on
  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0: r = 8'h2C;
      4'd1: r = 8'h28;
      4'd2: r = 8'h2C;
      4'd3: r = 8'h28;
      4'd4: r = 8'h8C;
      4'd5: r = 8'h88;
      4'd6: r = 8'h0C;
      4'd7: r = 8'h08;
      4'd8: r = 8'hCC;
      4'd9: r = 8'hC8;
      4'd10: r = 8'h0C;
      4'd11: r = 8'h08;
      4'd12: r = 8'h6C;
      default: r = 8'h68;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/clnw_front.sv =====
// front end: accepts items, tracks the current line and queues jobs
module clnw_front
  import clnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] data_byte,
  input  logic [5:0] column,
  input  logic [2:0] row,
  input  logic       four_line_mode,
  input  q_status_t  q_status,
  output logic       push,
  output job_t       push_job
);

  logic [2:0] current_line;
  logic [2:0] current_line_next;
  logic [2:0] num_lines;
  logic [2:0] eff_line;
  logic [2:0] nl_line;
  logic [5:0] col_clamped;
  logic       job_ok;
  logic       accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // layout size, the line to use for relative moves and the clamped column
  always_comb begin
    num_lines = four_line_mode ? 3'd4 : 3'd2;
    if (current_line == 3'd0 || current_line > num_lines) begin
      eff_line = 3'd1;
    end else begin
      eff_line = current_line;
    end
    nl_line = (eff_line >= num_lines) ? 3'd1 : eff_line + 3'd1;
    if (column == 6'd0) begin
      col_clamped = 6'd1;
    end else if (column > COL_MAX) begin
      col_clamped = COL_MAX;
    end else begin
      col_clamped = column;
    end
  end

  // classify the item into at most one job
  always_comb begin
    job_ok            = 1'b1;
    current_line_next = current_line;
    push_job.kind     = JOB_BYTE;
    push_job.value    = data_byte;
    push_job.rs       = 1'b0;
    unique case (action)
      ACT_TEXT: begin
        priority if (data_byte == CH_NEWLINE) begin
          current_line_next = nl_line;
          push_job.value    = line_start(2'(nl_line - 3'd1));
        end else if (data_byte == CH_RETURN) begin
          push_job.value = line_start(2'(eff_line - 3'd1));
        end else if (data_byte == CH_BELL) begin
          current_line_next = 3'd1;
          push_job.value    = LINE1_CMD;
        end else if (data_byte == CH_FORMFEED) begin
          current_line_next = 3'd1;
          push_job.value    = CLEAR_CMD;
        end else begin
          push_job.rs = 1'b1;
        end
      end
      ACT_COMMAND: begin
        push_job.value = data_byte;
      end
      ACT_CURSOR: begin
        job_ok         = (row != 3'd0) && (row <= num_lines);
        push_job.value = line_start(2'(row - 3'd1)) + {2'b00, col_clamped} - 8'd1;
      end
      ACT_INIT: begin
        push_job.kind = JOB_INIT;
      end
      ACT_LIGHT: begin
        push_job.kind = JOB_LIGHT;
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase
    push_job.lw = !push_job.rs && (push_job.kind == JOB_BYTE) &&
                  (push_job.value == CLEAR_CMD || push_job.value == HOME_CMD_A ||
                   push_job.value == HOME_CMD_B);
  end

  assign push = accept && job_ok;

  // current line register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_line <= 3'd1;
    end else if (accept) begin
      current_line <= current_line_next;
    end
  end

endmodule

// ===== hdl/clnw_queue.sv =====
// job queue between the front end and the byte sequencer
module clnw_queue
  import clnw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign head           = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/clnw_back.sv =====
// back end: steps through the queued job and drives the output register
module clnw_back
  import clnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  input  logic       backlight_on,
  input  logic       expander_variant_a,
  input  logic [2:0] address_pins,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] expander_byte,
  output logic       is_address,
  output logic       last,
  output logic       long_wait
);

  logic [STEP_W-1:0] step;
  logic              emit;
  logic [7:0]        byte_n;
  logic              addr_n;
  logic              last_n;
  logic [7:0]        addr_byte;
  logic              bl;

  assign bl        = backlight_on;
  assign addr_byte = (expander_variant_a ? ADDR_BASE_A : ADDR_BASE_B) |
                     {4'b0000, address_pins, 1'b0};
  assign emit      = !q_status.empty && (!out_valid || !out_stall);
  assign pop       = emit && last_n;

  // byte for the current step of the head job
  always_comb begin
    byte_n = addr_byte;
    addr_n = 1'b0;
    last_n = 1'b0;
    if (step == '0) begin
      addr_n = 1'b1;
    end else begin
      unique case (head.kind)
        JOB_BYTE: begin
          last_n = (step == BYTE_LAST_STEP);
          unique case (step[1:0])
            2'd1: byte_n = {head.value[7:4], bl, 1'b1, 1'b0, head.rs};
            2'd2: byte_n = {head.value[7:4], bl, 1'b0, 1'b0, head.rs};
            2'd3: byte_n = {head.value[3:0], bl, 1'b1, 1'b0, head.rs};
            default: byte_n = {head.value[3:0], bl, 1'b0, 1'b0, head.rs};
          endcase
        end
        JOB_INIT: begin
          last_n = (step == INIT_LAST_STEP);
          byte_n = init_byte(step - 1'b1);
        end
        default: begin
          last_n = 1'b1;
          byte_n = {4'b0000, bl, 3'b000};
        end
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (emit) begin
      step <= last_n ? '0 : step + 1'b1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !q_status.empty;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      expander_byte <= byte_n;
      is_address    <= addr_n;
      last          <= last_n;
      long_wait     <= last_n && head.lw && (head.kind == JOB_BYTE);
    end
  end

endmodule

// ===== hdl/char_lcd_i2c_nibble_writer.sv =====
// top level: config registers, front end, job queue and byte sequencer
//
// Turns text, commands, cursor moves, init and backlight refresh items into
// bytes for an I2C port expander driving a 4-bit character LCD.
// Input channel: in_valid/in_stall, a beat moves action, data_byte, column
// and row. Output channel: out_valid/out_stall, a beat moves one expander
// byte with is_address, last and long_wait.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index picks the
// register, cfg_data carries its value; write only while idle.
// An item is written into the job queue and its address byte then into the
// output register, if the queue was empty and the output is not stalled.
// The sequencer puts out one byte a cycle unless stalled: text, command and
// cursor items give 5 bytes, init 15, backlight refresh 2; items giving no
// bytes take no sequencer time; the single byte sequencer sets throughput.
// The job queue holds QUEUE_DEPTH items, so input beats keep being taken
// while the sequencer works; in_stall rises only when the queue is full.
// When the receiver stalls, the output register holds its byte, the
// sequencer waits and the queue fills up.
// Reset empties the queue and output, sets line one, backlight on, two-line
// layout, address base 0x40 and address pins 0.
module char_lcd_i2c_nibble_writer
  import clnw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] data_byte,
  input  logic [5:0] column,
  input  logic [2:0] row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] expander_byte,
  output logic       is_address,
  output logic       last,
  output logic       long_wait,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  logic       backlight_on;
  logic       four_line_mode;
  logic       expander_variant_a;
  logic [2:0] address_pins;

  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;
  q_status_t  q_status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on       <= 1'b1;
      four_line_mode     <= 1'b0;
      expander_variant_a <= 1'b0;
      address_pins       <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BACKLIGHT: backlight_on       <= cfg_data[0];
        REG_FOUR_LINE: four_line_mode     <= cfg_data[0];
        REG_VARIANT:   expander_variant_a <= cfg_data[0];
        default:       address_pins       <= cfg_data;
      endcase
    end
  end

  // item classification
  clnw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .data_byte      (data_byte),
    .column         (column),
    .row            (row),
    .four_line_mode (four_line_mode),
    .q_status       (q_status),
    .push           (push),
    .push_job       (push_job)
  );

  // job queue
  clnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // byte sequencer
  clnw_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .q_status           (q_status),
    .pop                (pop),
    .backlight_on       (backlight_on),
    .expander_variant_a (expander_variant_a),
    .address_pins       (address_pins),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .expander_byte      (expander_byte),
    .is_address         (is_address),
    .last               (last),
    .long_wait          (long_wait)
  );

`ifndef NO_ASSERTIONS
  // an empty queue never holds off the input
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !in_stall)
    else $error("input stalled with empty queue");

  // long wait only on the closing byte, never on an address byte
  a_long_wait_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_wait) |-> (last && !is_address))
    else $error("long_wait outside closing byte");

  // a run continues without a gap once a non-final byte is taken
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("gap inside a byte run");

  // the queue is never drained while a run is still open
  a_open_run_queued: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |-> !q_status.empty)
    else $error("queue empty during open run");
`endif

endmodule
